// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, command codes and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    // command codes carried in the input tuser
    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_POLAR = 3'd4
    } t_cmd;

    // angle datapath
    localparam int CORW      = 64;     // CORDIC x/y width
    localparam int ZW        = 33;     // angle accumulator width, 30 fraction bits
    localparam int ATW       = 30;     // width of one arctangent table entry
    localparam int ANG_FRAC  = 30;
    localparam int ANG_W     = 16;     // output angle, Q3.13
    localparam int ANG_MAX   = 25736;
    localparam int TABLE_LEN = 24;

    // per-stage control that rides along with each word
    typedef struct packed {
        logic vld;
        t_cmd cmd;
        logic ovf;      // add/sub/mul result saturated
        logic dz;       // zero divisor
        logic neg_re;   // sign of real quotient
        logic neg_im;   // sign of imaginary quotient
        logic big_re;   // real quotient far out of range
        logic big_im;
        logic zvec;     // polar operand is the zero vector
    } t_ctl;

    // atan(2^-idx) in units of 2^-30 rad
    function automatic logic [ATW-1:0] f_atan(input logic [4:0] idx);
        logic [ATW-1:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/complex_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Pipelined complex ALU: add, sub, mul, div and polar form on fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: tuser = cmd (0 add, 1 sub, 2 mul, 3 div, 4 polar of a),
//    tdata = a_re, a_im, b_re, b_im (signed, FRAC_BITS fraction bits).
//  - Master stream: one word per input word, in order. tdata = res_re,
//    res_im, magnitude, angle (Q3.13 rad); tuser = overflow, div_zero.
//  - Pipeline: stages A to D, the iterative stages and the output register
//    lie between accept and tvalid. The iterative depth is the larger of
//    DATA_WIDTH+1 (bit-per-stage divider, one quotient bit each) and
//    CORDIC_STEPS; square root and CORDIC run in the same stages beside it.
//  - Throughput: one word per cycle while not stalled; a valid bit per stage.
//  - Stall: the whole pipe freezes while the output word waits; s_tready
//    is low only then, so nothing is lost or repeated.
//  - Reset (synchronous, active low) clears all valid bits; no clearing
//    pass, the pipe takes words in the first cycle after reset.
// ----------------------------------------------------------------------------
module complex_arith_unit_core #(
    parameter int DATA_WIDTH   = 16,
    parameter int FRAC_BITS    = 8,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // tdata: a_re, a_im, b_re, b_im (lowest first), zero padded
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // tuser: cmd
    input  logic [2:0]                              i_s_tuser,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // tdata: res_re, res_im, magnitude, angle (lowest first), zero padded
    output logic [((3*DATA_WIDTH+16+7)/8)*8-1:0]    o_m_tdata,
    // tuser: overflow, div_zero (lowest first)
    output logic [1:0]                              o_m_tuser
);
    import cau_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int RW  = 2 * W;
    localparam int DW1 = 2 * W + 1;
    localparam int OW  = ((3*DATA_WIDTH+16+7)/8)*8;
    localparam int NS  = (W + 1 > CORDIC_STEPS) ? W + 1 : CORDIC_STEPS;
    localparam int CSH = 60 - W;
    localparam logic [DW1-1:0] RND_HALF = DW1'((1 << F) >> 1);
    localparam logic signed [ZW-1:0] ATN2 = ZW'(f_atan(5'd0)) <<< 1;

    // saturate sign/magnitude to W bits: returns {ovf, value}
    function automatic logic [W:0] f_sat(input logic neg, input logic [DW1-1:0] mag);
        logic [DW1-1:0] lim;
        logic [DW1-1:0] m;
        logic           ov;
        lim = (DW1'(1) << (W - 1)) - DW1'(!neg);
        ov  = (mag > lim);
        m   = ov ? lim : mag;
        return {ov, neg ? -m[W-1:0] : m[W-1:0]};
    endfunction

    logic w_ce;
    assign w_ce       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_ce;

    // ---------------- stage A: input register ----------------
    logic                 r_a_vld;
    t_cmd                 r_a_cmd;
    logic signed [W-1:0]  r_a_ar, r_a_ai, r_a_br, r_a_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_ce) begin
            r_a_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_cmd <= t_cmd'(i_s_tuser);
            r_a_ar  <= i_s_tdata[W-1:0];
            r_a_ai  <= i_s_tdata[2*W-1:W];
            r_a_br  <= i_s_tdata[3*W-1:2*W];
            r_a_bi  <= i_s_tdata[4*W-1:3*W];
        end
    end

    // ---------------- stage B: products, add/sub ----------------
    logic                  r_b_vld;
    t_cmd                  r_b_cmd;
    logic signed [RW-1:0]  r_b_arbr, r_b_aibi, r_b_arbi, r_b_aibr;
    logic signed [RW-1:0]  r_b_brbr, r_b_bibi, r_b_arar, r_b_aiai;
    logic signed [W:0]     r_b_sre, r_b_sim;
    logic signed [W-1:0]   r_b_ar, r_b_ai;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_ce) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_b_cmd  <= r_a_cmd;
            r_b_arbr <= r_a_ar * r_a_br;
            r_b_aibi <= r_a_ai * r_a_bi;
            r_b_arbi <= r_a_ar * r_a_bi;
            r_b_aibr <= r_a_ai * r_a_br;
            r_b_brbr <= r_a_br * r_a_br;
            r_b_bibi <= r_a_bi * r_a_bi;
            r_b_arar <= r_a_ar * r_a_ar;
            r_b_aiai <= r_a_ai * r_a_ai;
            if (r_a_cmd == CMD_SUB) begin
                r_b_sre <= (W+1)'(r_a_ar) - (W+1)'(r_a_br);
                r_b_sim <= (W+1)'(r_a_ai) - (W+1)'(r_a_bi);
            end else begin
                r_b_sre <= (W+1)'(r_a_ar) + (W+1)'(r_a_br);
                r_b_sim <= (W+1)'(r_a_ai) + (W+1)'(r_a_bi);
            end
            r_b_ar   <= r_a_ar;
            r_b_ai   <= r_a_ai;
        end
    end

    // ---------------- stage C: dot sums, den, radicand, pre-rotation ----
    logic                    r_c_vld;
    t_cmd                    r_c_cmd;
    logic signed [DW1-1:0]   r_c_dre, r_c_dim;
    logic [RW-1:0]           r_c_den, r_c_sq;
    logic signed [W:0]       r_c_sre, r_c_sim;
    logic signed [CORW-1:0]  r_c_x, r_c_y;
    logic signed [ZW-1:0]    r_c_z;
    logic                    r_c_zvec;

    logic signed [CORW-1:0]  n_c_x, n_c_y, w_x0, w_y0;
    logic signed [ZW-1:0]    n_c_z;

    always_comb begin
        w_x0 = CORW'(r_b_ar) <<< CSH;
        w_y0 = CORW'(r_b_ai) <<< CSH;
        n_c_x = w_x0;
        n_c_y = w_y0;
        n_c_z = '0;
        // left half plane: turn by +-pi/2 first
        if (w_x0 < 0) begin
            if (w_y0 >= 0) begin
                n_c_x = w_y0;
                n_c_y = -w_x0;
                n_c_z = ATN2;
            end else begin
                n_c_x = -w_y0;
                n_c_y = w_x0;
                n_c_z = -ATN2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_ce) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c_cmd <= r_b_cmd;
            if (r_b_cmd == CMD_MUL) begin
                r_c_dre <= DW1'(r_b_arbr) - DW1'(r_b_aibi);
                r_c_dim <= DW1'(r_b_arbi) + DW1'(r_b_aibr);
            end else begin
                r_c_dre <= DW1'(r_b_arbr) + DW1'(r_b_aibi);
                r_c_dim <= DW1'(r_b_aibr) - DW1'(r_b_arbi);
            end
            r_c_den  <= $unsigned(r_b_brbr) + $unsigned(r_b_bibi);
            r_c_sq   <= $unsigned(r_b_arar) + $unsigned(r_b_aiai);
            r_c_sre  <= r_b_sre;
            r_c_sim  <= r_b_sim;
            r_c_x    <= n_c_x;
            r_c_y    <= n_c_y;
            r_c_z    <= n_c_z;
            r_c_zvec <= (r_b_ar == '0) && (r_b_ai == '0);
        end
    end

    // ---------------- stage D: round/saturate, divider setup ----------------
    logic [RW-1:0]        w_mre, w_mim;
    logic                 w_nre, w_nim;
    logic [DW1-1:0]       w_rre, w_rim;
    logic [W:0]           w_sat_re, w_sat_im;
    logic [RW+F-1:0]      w_dvd_re, w_dvd_im;
    logic [RW+F-1:0]      w_hi_re, w_hi_im;
    logic                 w_big_re, w_big_im;
    t_ctl                 n_d_ctl;

    always_comb begin
        w_nre    = r_c_dre[DW1-1];
        w_nim    = r_c_dim[DW1-1];
        w_mre    = RW'(w_nre ? -r_c_dre : r_c_dre);
        w_mim    = RW'(w_nim ? -r_c_dim : r_c_dim);
        w_rre    = (DW1'(w_mre) + RND_HALF) >> F;
        w_rim    = (DW1'(w_mim) + RND_HALF) >> F;
        w_dvd_re = (RW+F)'(w_mre) << F;
        w_dvd_im = (RW+F)'(w_mim) << F;
        w_hi_re  = w_dvd_re >> (W + 1);
        w_hi_im  = w_dvd_im >> (W + 1);
        w_big_re = (w_hi_re >= (RW+F)'(r_c_den));
        w_big_im = (w_hi_im >= (RW+F)'(r_c_den));
        if (r_c_cmd == CMD_MUL) begin
            w_sat_re = f_sat(w_nre && (w_rre != '0), w_rre);
            w_sat_im = f_sat(w_nim && (w_rim != '0), w_rim);
        end else begin
            w_sat_re = f_sat(r_c_sre[W], DW1'(r_c_sre[W] ? -r_c_sre : r_c_sre));
            w_sat_im = f_sat(r_c_sim[W], DW1'(r_c_sim[W] ? -r_c_sim : r_c_sim));
        end
        n_d_ctl.vld    = r_c_vld;
        n_d_ctl.cmd    = r_c_cmd;
        n_d_ctl.ovf    = w_sat_re[W] | w_sat_im[W];
        n_d_ctl.dz     = (r_c_den == '0);
        n_d_ctl.neg_re = w_nre && (w_mre != '0);
        n_d_ctl.neg_im = w_nim && (w_mim != '0);
        n_d_ctl.big_re = w_big_re;
        n_d_ctl.big_im = w_big_im;
        n_d_ctl.zvec   = r_c_zvec;
    end

    t_ctl                   r_d_ctl;
    logic [W-1:0]           r_d_res_re, r_d_res_im;
    logic [W:0]             r_d_dvd_re, r_d_dvd_im;
    logic [RW-1:0]          r_d_rem_re, r_d_rem_im;
    logic [RW-1:0]          r_d_den, r_d_sq;
    logic signed [CORW-1:0] r_d_x, r_d_y;
    logic signed [ZW-1:0]   r_d_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else if (w_ce) begin
            r_d_ctl <= n_d_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_d_res_re <= w_sat_re[W-1:0];
            r_d_res_im <= w_sat_im[W-1:0];
            r_d_dvd_re <= w_dvd_re[W:0];
            r_d_dvd_im <= w_dvd_im[W:0];
            // a quotient out of range never uses the remainder
            r_d_rem_re <= w_big_re ? '0 : RW'(w_hi_re);
            r_d_rem_im <= w_big_im ? '0 : RW'(w_hi_im);
            r_d_den    <= r_c_den;
            r_d_sq     <= r_c_sq;
            r_d_x      <= r_c_x;
            r_d_y      <= r_c_y;
            r_d_z      <= r_c_z;
        end
    end

    // ---------------- iterative stages ----------------
    t_ctl                   s_ctl    [0:NS];
    logic [W-1:0]           s_res_re [0:NS];
    logic [W-1:0]           s_res_im [0:NS];
    logic [W:0]             s_dvd_re [0:NS];
    logic [W:0]             s_dvd_im [0:NS];
    logic [RW-1:0]          s_rem_re [0:NS];
    logic [RW-1:0]          s_rem_im [0:NS];
    logic [W:0]             s_q_re   [0:NS];
    logic [W:0]             s_q_im   [0:NS];
    logic [RW-1:0]          s_den    [0:NS];
    logic [RW-1:0]          s_sq     [0:NS];
    logic [W:0]             s_srem   [0:NS];
    logic [W-1:0]           s_root   [0:NS];
    logic signed [CORW-1:0] s_x      [0:NS];
    logic signed [CORW-1:0] s_y      [0:NS];
    logic signed [ZW-1:0]   s_z      [0:NS];

    assign s_ctl[0]    = r_d_ctl;
    assign s_res_re[0] = r_d_res_re;
    assign s_res_im[0] = r_d_res_im;
    assign s_dvd_re[0] = r_d_dvd_re;
    assign s_dvd_im[0] = r_d_dvd_im;
    assign s_rem_re[0] = r_d_rem_re;
    assign s_rem_im[0] = r_d_rem_im;
    assign s_q_re[0]   = '0;
    assign s_q_im[0]   = '0;
    assign s_den[0]    = r_d_den;
    assign s_sq[0]     = r_d_sq;
    assign s_srem[0]   = '0;
    assign s_root[0]   = '0;
    assign s_x[0]      = r_d_x;
    assign s_y[0]      = r_d_y;
    assign s_z[0]      = r_d_z;

    generate
        for (genvar k = 0; k < NS; k++) begin : g_it
            cau_iter_stage #(
                .DATA_WIDTH   (DATA_WIDTH),
                .CORDIC_STEPS (CORDIC_STEPS),
                .STAGE        (k)
            ) u_stage (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ce     (w_ce),
                .i_ctl    (s_ctl[k]),
                .o_ctl    (s_ctl[k+1]),
                .i_res_re (s_res_re[k]),
                .i_res_im (s_res_im[k]),
                .o_res_re (s_res_re[k+1]),
                .o_res_im (s_res_im[k+1]),
                .i_dvd_re (s_dvd_re[k]),
                .i_dvd_im (s_dvd_im[k]),
                .o_dvd_re (s_dvd_re[k+1]),
                .o_dvd_im (s_dvd_im[k+1]),
                .i_rem_re (s_rem_re[k]),
                .i_rem_im (s_rem_im[k]),
                .o_rem_re (s_rem_re[k+1]),
                .o_rem_im (s_rem_im[k+1]),
                .i_q_re   (s_q_re[k]),
                .i_q_im   (s_q_im[k]),
                .o_q_re   (s_q_re[k+1]),
                .o_q_im   (s_q_im[k+1]),
                .i_den    (s_den[k]),
                .o_den    (s_den[k+1]),
                .i_sq     (s_sq[k]),
                .o_sq     (s_sq[k+1]),
                .i_srem   (s_srem[k]),
                .o_srem   (s_srem[k+1]),
                .i_root   (s_root[k]),
                .o_root   (s_root[k+1]),
                .i_x      (s_x[k]),
                .i_y      (s_y[k]),
                .o_x      (s_x[k+1]),
                .o_y      (s_y[k+1]),
                .i_z      (s_z[k]),
                .o_z      (s_z[k+1])
            );
        end
    endgenerate

    // ---------------- final stage: rounding, select, output register -------
    t_ctl                 w_c;
    logic [W+1:0]         w_qre, w_qim;
    logic [DW1-1:0]       w_dmre, w_dmim;
    logic [W:0]           w_dsre, w_dsim;
    logic [ZW-1:0]        w_zmag;
    logic [ZW-1:0]        w_zr;
    logic [ANG_W-1:0]     w_am;
    logic [W-1:0]         n_re, n_im, n_mg;
    logic [ANG_W-1:0]     n_ang;
    logic                 n_ovf, n_dz;

    always_comb begin
        w_c    = s_ctl[NS];
        // quotient rounding: up when twice the remainder reaches the divisor
        w_qre  = (W+2)'(s_q_re[NS]) + (W+2)'({s_rem_re[NS], 1'b0} >= {1'b0, s_den[NS]});
        w_qim  = (W+2)'(s_q_im[NS]) + (W+2)'({s_rem_im[NS], 1'b0} >= {1'b0, s_den[NS]});
        w_dmre = w_c.big_re ? {1'b1, {RW{1'b0}}} : DW1'(w_qre);
        w_dmim = w_c.big_im ? {1'b1, {RW{1'b0}}} : DW1'(w_qim);
        w_dsre = f_sat(w_c.neg_re && (w_dmre != '0), w_dmre);
        w_dsim = f_sat(w_c.neg_im && (w_dmim != '0), w_dmim);
        // angle: round 30 fraction bits to 13, clamp to +-pi
        w_zmag = s_z[NS][ZW-1] ? -s_z[NS] : s_z[NS];
        w_zr   = (w_zmag + (ZW'(1) << (ANG_FRAC - 14))) >> (ANG_FRAC - 13);
        w_am   = (w_zr > ZW'(ANG_MAX)) ? ANG_W'(ANG_MAX) : w_zr[ANG_W-1:0];

        n_re  = '0;
        n_im  = '0;
        n_mg  = '0;
        n_ang = '0;
        n_ovf = 1'b0;
        n_dz  = 1'b0;
        case (w_c.cmd) inside
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                n_re  = s_res_re[NS];
                n_im  = s_res_im[NS];
                n_ovf = w_c.ovf;
            end
            CMD_DIV: begin
                if (w_c.dz) begin
                    n_dz = 1'b1;
                end else begin
                    n_re  = w_dsre[W-1:0];
                    n_im  = w_dsim[W-1:0];
                    n_ovf = w_dsre[W] | w_dsim[W];
                end
            end
            CMD_POLAR: begin
                if (!w_c.zvec) begin
                    n_mg  = s_root[NS] + W'(s_srem[NS] > {1'b0, s_root[NS]});
                    n_ang = s_z[NS][ZW-1] ? -w_am : w_am;
                end
            end
            default: begin
            end
        endcase
    end

    logic                 r_out_vld;
    logic [W-1:0]         r_out_re, r_out_im, r_out_mg;
    logic [ANG_W-1:0]     r_out_ang;
    logic                 r_out_ovf, r_out_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ce) begin
            r_out_vld <= w_c.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_out_re  <= n_re;
            r_out_im  <= n_im;
            r_out_mg  <= n_mg;
            r_out_ang <= n_ang;
            r_out_ovf <= n_ovf;
            r_out_dz  <= n_dz;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OW'({r_out_ang, r_out_mg, r_out_im, r_out_re});
    assign o_m_tuser  = {r_out_dz, r_out_ovf};

    // ---------------- assertions ----------------
    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(r_out_dz && r_out_ovf))
        else $error("div_zero and overflow both set");

    a_polar_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_out_mg != '0)) |->
            (r_out_re == '0) && (r_out_im == '0) && !r_out_ovf && !r_out_dz)
        else $error("polar word carries rectangular fields");

    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (($signed(r_out_ang) <= $signed(ANG_W'(ANG_MAX))) &&
                        ($signed(r_out_ang) >= -$signed(ANG_W'(ANG_MAX)))))
        else $error("angle out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== hw/rtl/cau_iter_stage.sv =====
// ----------------------------------------------------------------------------
// cau_iter_stage
// One pipeline stage of the iterative units, each unit active in its range:
// a quotient bit for both dividers, a root bit, a CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module cau_iter_stage #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 16,
    parameter int STAGE        = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ce,
    input  cau_pkg::t_ctl                      i_ctl,
    output cau_pkg::t_ctl                      o_ctl,
    input  logic [DATA_WIDTH-1:0]              i_res_re,
    input  logic [DATA_WIDTH-1:0]              i_res_im,
    output logic [DATA_WIDTH-1:0]              o_res_re,
    output logic [DATA_WIDTH-1:0]              o_res_im,
    input  logic [DATA_WIDTH:0]                i_dvd_re,
    input  logic [DATA_WIDTH:0]                i_dvd_im,
    output logic [DATA_WIDTH:0]                o_dvd_re,
    output logic [DATA_WIDTH:0]                o_dvd_im,
    input  logic [2*DATA_WIDTH-1:0]            i_rem_re,
    input  logic [2*DATA_WIDTH-1:0]            i_rem_im,
    output logic [2*DATA_WIDTH-1:0]            o_rem_re,
    output logic [2*DATA_WIDTH-1:0]            o_rem_im,
    input  logic [DATA_WIDTH:0]                i_q_re,
    input  logic [DATA_WIDTH:0]                i_q_im,
    output logic [DATA_WIDTH:0]                o_q_re,
    output logic [DATA_WIDTH:0]                o_q_im,
    input  logic [2*DATA_WIDTH-1:0]            i_den,
    output logic [2*DATA_WIDTH-1:0]            o_den,
    input  logic [2*DATA_WIDTH-1:0]            i_sq,
    output logic [2*DATA_WIDTH-1:0]            o_sq,
    input  logic [DATA_WIDTH:0]                i_srem,
    output logic [DATA_WIDTH:0]                o_srem,
    input  logic [DATA_WIDTH-1:0]              i_root,
    output logic [DATA_WIDTH-1:0]              o_root,
    input  logic signed [cau_pkg::CORW-1:0]    i_x,
    input  logic signed [cau_pkg::CORW-1:0]    i_y,
    output logic signed [cau_pkg::CORW-1:0]    o_x,
    output logic signed [cau_pkg::CORW-1:0]    o_y,
    input  logic signed [cau_pkg::ZW-1:0]      i_z,
    output logic signed [cau_pkg::ZW-1:0]      o_z
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int RW = 2 * DATA_WIDTH;

    // restoring divide step: returns {quotient bit, new remainder}
    function automatic logic [RW:0] f_dstep(input logic [RW-1:0] rem, input logic bin,
                                            input logic [RW-1:0] den);
        logic [RW-1:0] sh;
        logic          ge;
        sh = {rem[RW-2:0], bin};
        ge = (sh >= den);
        return {ge, ge ? sh - den : sh};
    endfunction

    logic [RW-1:0]             n_rem_re, n_rem_im;
    logic [W:0]                n_q_re, n_q_im;
    logic [W:0]                n_srem;
    logic [W-1:0]              n_root;
    logic signed [CORW-1:0]    n_x, n_y;
    logic signed [ZW-1:0]      n_z;

    t_ctl                      r_ctl;
    logic [W-1:0]              r_res_re, r_res_im;
    logic [W:0]                r_dvd_re, r_dvd_im;
    logic [RW-1:0]             r_rem_re, r_rem_im;
    logic [W:0]                r_q_re, r_q_im;
    logic [RW-1:0]             r_den, r_sq;
    logic [W:0]                r_srem;
    logic [W-1:0]              r_root;
    logic signed [CORW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]      r_z;

    // divider bit
    generate
        if (STAGE <= W) begin : g_div
            localparam int DB = W - STAGE;
            logic [RW:0] w_re, w_im;
            always_comb begin
                w_re     = f_dstep(i_rem_re, i_dvd_re[DB], i_den);
                w_im     = f_dstep(i_rem_im, i_dvd_im[DB], i_den);
                n_rem_re = w_re[RW-1:0];
                n_rem_im = w_im[RW-1:0];
                n_q_re   = {i_q_re[W-1:0], w_re[RW]};
                n_q_im   = {i_q_im[W-1:0], w_im[RW]};
            end
        end else begin : g_nodiv
            always_comb begin
                n_rem_re = i_rem_re;
                n_rem_im = i_rem_im;
                n_q_re   = i_q_re;
                n_q_im   = i_q_im;
            end
        end
    endgenerate

    // square root bit, two radicand bits per step
    generate
        if (STAGE < W) begin : g_sqrt
            localparam int P = W - 1 - STAGE;
            logic [W+2:0] w_sh, w_t;
            logic         w_ge;
            always_comb begin
                w_sh   = {i_srem, i_sq[2*P+1 -: 2]};
                w_t    = {1'b0, i_root, 2'b01};
                w_ge   = (w_sh >= w_t);
                n_srem = w_ge ? (W+1)'(w_sh - w_t) : (W+1)'(w_sh);
                n_root = {i_root[W-2:0], w_ge};
            end
        end else begin : g_nosqrt
            always_comb begin
                n_srem = i_srem;
                n_root = i_root;
            end
        end
    endgenerate

    // CORDIC micro-rotation
    generate
        if (STAGE < CORDIC_STEPS) begin : g_cordic
            localparam logic signed [ZW-1:0] ATN = ZW'(f_atan(5'(STAGE)));
            logic signed [CORW-1:0] w_dx, w_dy;
            always_comb begin
                w_dx = i_y >>> STAGE;
                w_dy = i_x >>> STAGE;
                if (!i_y[CORW-1]) begin
                    n_x = i_x + w_dx;
                    n_y = i_y - w_dy;
                    n_z = i_z + ATN;
                end else begin
                    n_x = i_x - w_dx;
                    n_y = i_y + w_dy;
                    n_z = i_z - ATN;
                end
            end
        end else begin : g_nocordic
            always_comb begin
                n_x = i_x;
                n_y = i_y;
                n_z = i_z;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_ce) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_res_re <= i_res_re;
            r_res_im <= i_res_im;
            r_dvd_re <= i_dvd_re;
            r_dvd_im <= i_dvd_im;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
            r_den    <= i_den;
            r_sq     <= i_sq;
            r_srem   <= n_srem;
            r_root   <= n_root;
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_dvd_re = r_dvd_re;
    assign o_dvd_im = r_dvd_im;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_den    = r_den;
    assign o_sq     = r_sq;
    assign o_srem   = r_srem;
    assign o_root   = r_root;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_z      = r_z;

endmodule
